/* src/cevsel_pkg.sv */
package cevsel_pkg;

    localparam int PT_W    = 16;
    localparam int ETA_W   = 12;
    localparam int BTAG_W  = 12;
    localparam int ECUT_W  = 11;
    localparam int JCNT_W  = 8;
    localparam int SUM_W   = 20;
    localparam int CIDX_W  = 4;
    localparam int CDATA_W = 16;

    localparam logic [SUM_W-1:0] SUM_MAX    = '1;
    localparam int unsigned      MIN_TAGGED = 2;

    // Object kind codes
    typedef enum logic [1:0] {
        KIND_MUON     = 2'd0,
        KIND_ELECTRON = 2'd1,
        KIND_JET      = 2'd2,
        KIND_EVT_END  = 2'd3
    } obj_kind_t;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_TIGHT_PT   = 4'd0;
    localparam logic [CIDX_W-1:0] REG_LOOSE_PT   = 4'd1;
    localparam logic [CIDX_W-1:0] REG_TIGHT_ETA  = 4'd2;
    localparam logic [CIDX_W-1:0] REG_LOOSE_ETA  = 4'd3;
    localparam logic [CIDX_W-1:0] REG_BTAG       = 4'd4;
    localparam logic [CIDX_W-1:0] REG_MET        = 4'd5;
    localparam logic [CIDX_W-1:0] REG_JETS_SGL   = 4'd6;
    localparam logic [CIDX_W-1:0] REG_JETS_HAD   = 4'd7;

    typedef struct packed {
        logic [PT_W-1:0]          tight_pt_cut;
        logic [PT_W-1:0]          loose_pt_cut;
        logic [ECUT_W-1:0]        tight_eta_cut;
        logic [ECUT_W-1:0]        loose_eta_cut;
        logic signed [BTAG_W-1:0] btag_cut;
        logic [PT_W-1:0]          met_cut;
        logic [JCNT_W-1:0]        min_jets_single;
        logic [JCNT_W-1:0]        min_jets_hadron;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        tight_pt_cut:    16'd480,
        loose_pt_cut:    16'd240,
        tight_eta_cut:   11'd614,
        loose_eta_cut:   11'd640,
        btag_cut:        12'sd512,
        met_cut:         16'd480,
        min_jets_single: 8'd4,
        min_jets_hadron: 8'd6
    };

    // Per-object classification handed from classifier to accumulator
    typedef struct packed {
        logic is_muon;
        logic is_electron;
        logic is_jet;
        logic is_end;
        logic tight;
        logic loose;
        logic tag_hit;
        logic met_ok;
    } obj_class_t;

    typedef struct packed {
        logic             single_pass;
        logic             dilep_pass;
        logic             hadron_pass;
        logic [PT_W-1:0]  muon_max;
        logic [PT_W-1:0]  electron_max;
        logic [PT_W-1:0]  jet_max;
        logic [SUM_W-1:0] jet_sum;
    } result_t;

endpackage

/* src/cevsel_classify.sv */
module cevsel_classify (
    input  cevsel_pkg::cfg_t                          cfg,
    input  logic [1:0]                                kind,
    input  logic [cevsel_pkg::PT_W-1:0]               pt,
    input  logic signed [cevsel_pkg::ETA_W-1:0]       eta,
    input  logic signed [cevsel_pkg::BTAG_W-1:0]      btag,
    output cevsel_pkg::obj_class_t                    cls
);
    import cevsel_pkg::*;

    logic [ETA_W-1:0] abs_eta;
    logic             tight_kin;
    logic             loose_kin;

    // Magnitude of eta; the most negative code maps to 2048, still fits 12 bits unsigned
    assign abs_eta   = eta[ETA_W-1] ? (~eta + ETA_W'(1)) : eta;
    assign tight_kin = (pt > cfg.tight_pt_cut) && (abs_eta < {1'b0, cfg.tight_eta_cut});
    assign loose_kin = (pt > cfg.loose_pt_cut) && (abs_eta < {1'b0, cfg.loose_eta_cut});

    always_comb
    begin
        cls             = '0;
        cls.is_muon     = (kind == KIND_MUON);
        cls.is_electron = (kind == KIND_ELECTRON);
        cls.is_jet      = (kind == KIND_JET);
        cls.is_end      = (kind == KIND_EVT_END);
        cls.tight       = tight_kin;
        // loose only counts leptons that missed the tight class
        cls.loose       = !tight_kin && loose_kin;
        cls.tag_hit     = tight_kin && (btag > cfg.btag_cut);
        cls.met_ok      = (pt > cfg.met_cut);
    end

endmodule

/* src/cevsel_accum.sv */
module cevsel_accum #(
    parameter int COUNTER_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  cevsel_pkg::obj_class_t             cls,
    input  logic [cevsel_pkg::PT_W-1:0]        pt,
    input  logic [cevsel_pkg::JCNT_W-1:0]      min_jets_single,
    input  logic [cevsel_pkg::JCNT_W-1:0]      min_jets_hadron,
    output cevsel_pkg::result_t                result
);
    import cevsel_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > JCNT_W) ? COUNTER_BITS : JCNT_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [COUNTER_BITS-1:0] tight_cnt_reg,  tight_cnt_next;
    logic [COUNTER_BITS-1:0] loose_cnt_reg,  loose_cnt_next;
    logic [COUNTER_BITS-1:0] good_cnt_reg,   good_cnt_next;
    logic [COUNTER_BITS-1:0] tagged_cnt_reg, tagged_cnt_next;
    logic [PT_W-1:0]         mu_peak_reg,    mu_peak_next;
    logic [PT_W-1:0]         el_peak_reg,    el_peak_next;
    logic [PT_W-1:0]         jet_peak_reg,   jet_peak_next;
    logic [SUM_W-1:0]        jet_sum_reg,    jet_sum_next;
    logic [SUM_W:0]          sum_wide;
    logic                    is_lepton;
    logic                    tags_ok;
    result_t                 result_reg,     result_next;

    function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + COUNTER_BITS'(1);
    endfunction

    assign is_lepton = cls.is_muon || cls.is_electron;
    assign sum_wide  = {1'b0, jet_sum_reg} + (SUM_W+1)'(pt);
    assign tags_ok   = (tagged_cnt_reg >= COUNTER_BITS'(MIN_TAGGED));

    always_comb
    begin
        tight_cnt_next  = tight_cnt_reg;
        loose_cnt_next  = loose_cnt_reg;
        good_cnt_next   = good_cnt_reg;
        tagged_cnt_next = tagged_cnt_reg;
        mu_peak_next    = mu_peak_reg;
        el_peak_next    = el_peak_reg;
        jet_peak_next   = jet_peak_reg;
        jet_sum_next    = jet_sum_reg;
        result_next     = result_reg;

        if (step)
        begin
            if (cls.is_end)
            begin
                result_next.single_pass  = (tight_cnt_reg == COUNTER_BITS'(1))
                                        && (loose_cnt_reg == '0) && cls.met_ok && tags_ok
                                        && (CMP_W'(good_cnt_reg) >= CMP_W'(min_jets_single));
                result_next.dilep_pass   = (tight_cnt_reg >= COUNTER_BITS'(2))
                                        && cls.met_ok && tags_ok;
                result_next.hadron_pass  = tags_ok
                                        && (CMP_W'(good_cnt_reg) >= CMP_W'(min_jets_hadron));
                result_next.muon_max     = mu_peak_reg;
                result_next.electron_max = el_peak_reg;
                result_next.jet_max      = jet_peak_reg;
                result_next.jet_sum      = jet_sum_reg;
                // clear event state for the next event
                tight_cnt_next  = '0;
                loose_cnt_next  = '0;
                good_cnt_next   = '0;
                tagged_cnt_next = '0;
                mu_peak_next    = '0;
                el_peak_next    = '0;
                jet_peak_next   = '0;
                jet_sum_next    = '0;
            end
            else if (is_lepton)
            begin
                if (cls.is_muon && (pt > mu_peak_reg))
                    mu_peak_next = pt;
                if (cls.is_electron && (pt > el_peak_reg))
                    el_peak_next = pt;
                if (cls.tight)
                    tight_cnt_next = bump(tight_cnt_reg);
                else if (cls.loose)
                    loose_cnt_next = bump(loose_cnt_reg);
            end
            else if (cls.is_jet)
            begin
                if (pt > jet_peak_reg)
                    jet_peak_next = pt;
                jet_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                if (cls.tight)
                    good_cnt_next = bump(good_cnt_reg);
                if (cls.tag_hit)
                    tagged_cnt_next = bump(tagged_cnt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tight_cnt_reg  <= '0;
            loose_cnt_reg  <= '0;
            good_cnt_reg   <= '0;
            tagged_cnt_reg <= '0;
            mu_peak_reg    <= '0;
            el_peak_reg    <= '0;
            jet_peak_reg   <= '0;
            jet_sum_reg    <= '0;
        end
        else
        begin
            tight_cnt_reg  <= tight_cnt_next;
            loose_cnt_reg  <= loose_cnt_next;
            good_cnt_reg   <= good_cnt_next;
            tagged_cnt_reg <= tagged_cnt_next;
            mu_peak_reg    <= mu_peak_next;
            el_peak_reg    <= el_peak_next;
            jet_peak_reg   <= jet_peak_next;
            jet_sum_reg    <= jet_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

/* src/collision_event_object_selector_unit.sv */
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    object_kind, object_pt, object_eta, object_btag
// out       source     out_valid / out_stall  *_pass flags, *_lead_pt, jet_pt_sum
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One object transaction per cycle, sustained while no event-end object waits. An input
// register is followed by classification and event accumulation in a single pass into
// the state and result registers.
// Reset (rst_n low) restores the register defaults and clears all event state.
// in_stall rises only when an event-end object waits on a full, stalled result
// register; muon, electron and jet objects never wait.
module collision_event_object_selector_unit #(
    parameter int COUNTER_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            object_kind,
    input  logic [cevsel_pkg::PT_W-1:0]           object_pt,
    input  logic signed [cevsel_pkg::ETA_W-1:0]   object_eta,
    input  logic signed [cevsel_pkg::BTAG_W-1:0]  object_btag,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  single_lepton_pass,
    output logic                                  dilepton_pass,
    output logic                                  hadron_pass,
    output logic [cevsel_pkg::PT_W-1:0]           muon_lead_pt,
    output logic [cevsel_pkg::PT_W-1:0]           electron_lead_pt,
    output logic [cevsel_pkg::PT_W-1:0]           jet_lead_pt,
    output logic [cevsel_pkg::SUM_W-1:0]          jet_pt_sum,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cevsel_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [cevsel_pkg::CDATA_W-1:0]        cfg_data
);
    import cevsel_pkg::*;

    cfg_t                     cfg_reg, cfg_next;
    logic                     s1_valid_reg, s1_valid_next;
    logic [1:0]               s1_kind_reg;
    logic [PT_W-1:0]          s1_pt_reg;
    logic signed [ETA_W-1:0]  s1_eta_reg;
    logic signed [BTAG_W-1:0] s1_btag_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     in_take;
    logic                     out_free;
    logic                     s1_adv;
    obj_class_t               s1_cls;
    result_t                  result;

    // Configuration: always ready; indexes past the register list are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIGHT_PT:  cfg_next.tight_pt_cut    = cfg_data;
                REG_LOOSE_PT:  cfg_next.loose_pt_cut    = cfg_data;
                REG_TIGHT_ETA: cfg_next.tight_eta_cut   = cfg_data[ECUT_W-1:0];
                REG_LOOSE_ETA: cfg_next.loose_eta_cut   = cfg_data[ECUT_W-1:0];
                REG_BTAG:      cfg_next.btag_cut        = $signed(cfg_data[BTAG_W-1:0]);
                REG_MET:       cfg_next.met_cut         = cfg_data;
                REG_JETS_SGL:  cfg_next.min_jets_single = cfg_data[JCNT_W-1:0];
                REG_JETS_HAD:  cfg_next.min_jets_hadron = cfg_data[JCNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Pipeline control: an event-end object holds in the input register while the
    // result register is occupied and stalled; every other object advances at once.
    assign out_free       = !out_valid_reg || !out_stall;
    assign s1_adv         = s1_valid_reg && (!s1_cls.is_end || out_free);
    assign in_stall       = s1_valid_reg && !s1_adv;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = (s1_adv && s1_cls.is_end) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: load on every accepted transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg <= object_kind;
            s1_pt_reg   <= object_pt;
            s1_eta_reg  <= object_eta;
            s1_btag_reg <= object_btag;
        end
    end

    cevsel_classify u_classify (
        .cfg  (cfg_reg),
        .kind (s1_kind_reg),
        .pt   (s1_pt_reg),
        .eta  (s1_eta_reg),
        .btag (s1_btag_reg),
        .cls  (s1_cls)
    );

    cevsel_accum #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (s1_adv),
        .cls             (s1_cls),
        .pt              (s1_pt_reg),
        .min_jets_single (cfg_reg.min_jets_single),
        .min_jets_hadron (cfg_reg.min_jets_hadron),
        .result          (result)
    );

    assign out_valid          = out_valid_reg;
    assign single_lepton_pass = result.single_pass;
    assign dilepton_pass      = result.dilep_pass;
    assign hadron_pass        = result.hadron_pass;
    assign muon_lead_pt       = result.muon_max;
    assign electron_lead_pt   = result.electron_max;
    assign jet_lead_pt        = result.jet_max;
    assign jet_pt_sum         = result.jet_sum;

endmodule

/* src/cevsel_checker.sv */
module cevsel_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  single_lepton_pass,
    input logic                                  dilepton_pass,
    input logic                                  hadron_pass,
    input logic [cevsel_pkg::PT_W-1:0]           muon_lead_pt,
    input logic [cevsel_pkg::PT_W-1:0]           electron_lead_pt,
    input logic [cevsel_pkg::PT_W-1:0]           jet_lead_pt,
    input logic [cevsel_pkg::SUM_W-1:0]          jet_pt_sum
);
    import cevsel_pkg::*;

    // Input waits only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result register free");

    // Exactly one tight lepton and two or more cannot both hold
    a_lep_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(single_lepton_pass && dilepton_pass))
        else $error("single and dilepton flags both set");

    // Largest jet never exceeds the jet sum
    a_max_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({4'd0, jet_lead_pt} <= jet_pt_sum))
        else $error("jet max above jet sum");

    // Any selection needs two tagged jets, so some jet carried momentum
    a_pass_jets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (single_lepton_pass || dilepton_pass || hadron_pass))
        |-> (jet_lead_pt != '0))
        else $error("selection passed with no jet momentum");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(muon_lead_pt)
            && $stable(electron_lead_pt) && $stable(jet_pt_sum)))
        else $error("stalled result changed");

endmodule

bind collision_event_object_selector_unit cevsel_checker u_cevsel_checker (.*);
